@@ sv/tcs_pkg.sv @@
`default_nettype none
package tcs_pkg;

  // store geometry
  localparam int MAX_COLS      = 128;
  localparam int HISTORY_LINES = 128;

  localparam int COL_W  = $clog2(MAX_COLS);           // cursor / column index
  localparam int NCOL_W = $clog2(MAX_COLS + 1);       // column count
  localparam int ROW_W  = $clog2(HISTORY_LINES);      // row index
  localparam int LINE_W = $clog2(HISTORY_LINES + 1);  // line count
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int RAM_DEPTH = HISTORY_LINES * (1 << COL_W);

  // field widths
  localparam int REQ_W   = 2;
  localparam int CHAR_W  = 8;
  localparam int DELTA_W = 8;
  localparam int RROW_W  = 7;
  localparam int RCOL_W  = 7;
  localparam int CURO_W  = 7;
  localparam int LINEO_W = 8;
  localparam int VIEWO_W = 7;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_COLS_W = 8;
  localparam logic REG_IDX_COLS = 1'b0;
  localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;

  // characters
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TILDE     = 8'h7E;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE  = 2'd0,
    REQ_SCROLL = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_EXEC  = 6'b000010,
    ST_PUT   = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_READ  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

endpackage
`default_nettype wire

@@ sv/tcs_ram.sv @@
`default_nettype none
module tcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ sv/text_console_scrollback_unit.sv @@
`default_nettype none
// channel   | signals                               | direction
// ----------+---------------------------------------+----------
// in_       | tvalid tready tdata[31:0] tuser[1:0]  | request in
// out_      | tvalid tready tdata[31:0]             | result out
// cfg_      | APB psel penable pwrite paddr pwdata  | register access
//
// one request at a time under a small sequencer; in_tready is high only in idle.
// work after a beat: scroll, backspace or dropped byte go EXEC then DONE, a read adds READ,
// a plain byte adds PUT; newline and clear sweep one row with spaces in SWEEP; a byte that
// ends its line sweeps after PUT, one past a narrowed line sweeps before PUT, or both.
// after reset a clearing pass blanks row 0 before any beat is taken.
// a result waits in the output register; the next request runs meanwhile, done stalls if full.
module text_console_scrollback_unit (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  // char_code[7:0] scroll_delta[15:8] read_row[22:16] read_col[29:23]
  input  wire logic [tcs_pkg::IN_DATA_W-1:0]           in_tdata,
  // req_type[1:0]
  input  wire logic [tcs_pkg::REQ_W-1:0]               in_tuser,
  input  wire logic                                    in_tvalid,
  output logic                                         in_tready,
  // read_char[7:0] cursor_pos[14:8] lines_used[22:15] view_offset[29:23]
  output logic      [tcs_pkg::OUT_DATA_W-1:0]          out_tdata,
  output logic                                         out_tvalid,
  input  wire logic                                    out_tready,
  input  wire logic                                    cfg_psel,
  input  wire logic                                    cfg_penable,
  input  wire logic                                    cfg_pwrite,
  input  wire logic [tcs_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  wire logic [tcs_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic      [tcs_pkg::CFG_DATA_W-1:0]          cfg_prdata,
  output logic                                         cfg_pready
);

  localparam int RW  = tcs_pkg::ROW_W;
  localparam int CW  = tcs_pkg::COL_W;
  localparam int NCW = tcs_pkg::NCOL_W;
  localparam int LW  = tcs_pkg::LINE_W;
  localparam int SUMW = ((LW > tcs_pkg::DELTA_W) ? LW : tcs_pkg::DELTA_W) + 1;
  localparam logic [RW:0] HIST_EXT = (RW+1)'(tcs_pkg::HISTORY_LINES);

  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] base,
                                             input logic [RW-1:0] r);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, r};
    if (s >= HIST_EXT) s = s - HIST_EXT;
    return s[RW-1:0];
  endfunction

  tcs_pkg::state_t state_r, state_nxt;

  // latched request
  tcs_pkg::req_t                   req_r;
  logic [tcs_pkg::CHAR_W-1:0]      ch_r;
  logic [tcs_pkg::DELTA_W-1:0]     delta_r;
  logic [tcs_pkg::RROW_W-1:0]      rrow_r;
  logic [tcs_pkg::RCOL_W-1:0]      rcol_r;

  // console state
  logic [CW-1:0]  cur_r, cur_nxt;
  logic [LW-1:0]  lt_r, lt_nxt;
  logic [RW-1:0]  sb_r, sb_nxt;
  logic [RW-1:0]  base_r, base_nxt;
  logic [tcs_pkg::HISTORY_LINES-1:0] row_valid_r, row_valid_nxt;
  logic [tcs_pkg::CFG_COLS_W-1:0]    cfg_cols_r;

  // sequencer bookkeeping
  logic [RW-1:0] sw_row_r, sw_row_nxt;
  logic [CW-1:0] sw_col_r, sw_col_nxt;
  logic          put_pend_r, put_pend_nxt;
  logic          boot_r, boot_nxt;
  logic          rd_hit_r, rd_hit_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic [tcs_pkg::CHAR_W-1:0] rd_char_r, rd_char_nxt;

  logic [tcs_pkg::OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                           out_tvalid_r, out_tvalid_nxt;

  // ram
  logic                         ram_we;
  logic [tcs_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [tcs_pkg::CHAR_W-1:0]   ram_wdata, ram_q;

  // derived
  logic [NCW-1:0] cols;
  logic [RW-1:0]  cur_row;
  logic [RW-1:0]  adv_row;
  logic [LW-1:0]  adv_lt;
  logic [RW-1:0]  adv_base;
  logic [NCW-1:0] cur_inc;
  logic [RW-1:0]  rd_phys;
  logic [SUMW-1:0] sc_sum, sc_amt;
  logic [tcs_pkg::DELTA_W-1:0] neg_delta;
  logic           printable;
  logic           in_beat;
  logic           cfg_wr;

  tcs_ram #(
    .WIDTH (tcs_pkg::CHAR_W),
    .DEPTH (tcs_pkg::RAM_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_tready  = (state_r == tcs_pkg::ST_IDLE);
  assign in_beat    = in_tvalid && in_tready;
  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == tcs_pkg::REG_IDX_COLS);
  assign cfg_prdata = (cfg_paddr[2] == tcs_pkg::REG_IDX_COLS) ?
                      tcs_pkg::CFG_DATA_W'(cfg_cols_r) : '0;

  always_comb begin
    if (cfg_cols_r == '0) begin
      cols = NCW'(1);
    end else if (32'(cfg_cols_r) > tcs_pkg::MAX_COLS) begin
      cols = NCW'(tcs_pkg::MAX_COLS);
    end else begin
      cols = NCW'(cfg_cols_r);
    end
  end

  assign cur_row   = phys_row(base_r, RW'(lt_r - LW'(1)));
  assign cur_inc   = NCW'(cur_r) + NCW'(1);
  assign printable = (ch_r >= tcs_pkg::CH_SPACE) && (ch_r <= tcs_pkg::CH_TILDE);
  assign rd_phys   = phys_row(base_r, RW'(rrow_r));
  assign neg_delta = ~delta_r + tcs_pkg::DELTA_W'(1);
  assign sc_sum    = SUMW'(sb_r) + SUMW'(delta_r);
  assign sc_amt    = SUMW'(neg_delta);

  // next line: grow the history, or rotate the ring once it is full
  always_comb begin
    if (32'(lt_r) < tcs_pkg::HISTORY_LINES) begin
      adv_lt   = lt_r + LW'(1);
      adv_base = base_r;
      adv_row  = phys_row(base_r, RW'(lt_r));
    end else begin
      adv_lt   = lt_r;
      adv_base = phys_row(base_r, RW'(1));
      adv_row  = base_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    lt_nxt         = lt_r;
    sb_nxt         = sb_r;
    base_nxt       = base_r;
    row_valid_nxt  = row_valid_r;
    sw_row_nxt     = sw_row_r;
    sw_col_nxt     = sw_col_r;
    put_pend_nxt   = put_pend_r;
    boot_nxt       = boot_r;
    rd_hit_nxt     = rd_hit_r;
    rd_vld_nxt     = rd_vld_r;
    rd_char_nxt    = rd_char_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    ram_we         = 1'b0;
    ram_waddr      = {sw_row_r, sw_col_r};
    ram_wdata      = tcs_pkg::CH_SPACE;
    ram_raddr      = {rd_phys, CW'(rcol_r)};

    case (state_r)
      tcs_pkg::ST_IDLE: begin
        if (in_beat) begin
          state_nxt = tcs_pkg::ST_EXEC;
        end
      end

      tcs_pkg::ST_EXEC: begin
        rd_char_nxt = '0;
        state_nxt   = tcs_pkg::ST_DONE;
        case (req_r)
          tcs_pkg::REQ_WRITE: begin
            sb_nxt = '0;
            if (ch_r == tcs_pkg::CH_NEWLINE) begin
              cur_nxt    = '0;
              lt_nxt     = adv_lt;
              base_nxt   = adv_base;
              sw_row_nxt = adv_row;
              sw_col_nxt = '0;
              state_nxt  = tcs_pkg::ST_SWEEP;
            end else if (ch_r == tcs_pkg::CH_BACKSPACE) begin
              if (cur_r != '0) begin
                cur_nxt   = cur_r - CW'(1);
                ram_we    = 1'b1;
                ram_waddr = {cur_row, cur_r - CW'(1)};
              end
            end else if (printable) begin
              if (NCW'(cur_r) >= cols) begin
                // cursor past a narrowed line: new line first, then place the byte
                cur_nxt      = '0;
                lt_nxt       = adv_lt;
                base_nxt     = adv_base;
                sw_row_nxt   = adv_row;
                sw_col_nxt   = '0;
                put_pend_nxt = 1'b1;
                state_nxt    = tcs_pkg::ST_SWEEP;
              end else begin
                state_nxt = tcs_pkg::ST_PUT;
              end
            end
          end
          tcs_pkg::REQ_SCROLL: begin
            if (delta_r[tcs_pkg::DELTA_W-1] == 1'b0) begin
              if (sc_sum < SUMW'(lt_r)) begin
                sb_nxt = RW'(sc_sum);
              end else begin
                sb_nxt = RW'(lt_r - LW'(1));
              end
            end else if (sc_amt > SUMW'(sb_r)) begin
              sb_nxt = '0;
            end else begin
              sb_nxt = RW'(SUMW'(sb_r) - sc_amt);
            end
          end
          tcs_pkg::REQ_CLEAR: begin
            cur_nxt       = '0;
            lt_nxt        = LW'(1);
            sb_nxt        = '0;
            base_nxt      = '0;
            row_valid_nxt = '0;
            sw_row_nxt    = '0;
            sw_col_nxt    = '0;
            state_nxt     = tcs_pkg::ST_SWEEP;
          end
          tcs_pkg::REQ_READ: begin
            rd_hit_nxt = (32'(rrow_r) < tcs_pkg::HISTORY_LINES) &&
                         (32'(rcol_r) < tcs_pkg::MAX_COLS);
            rd_vld_nxt = row_valid_r[rd_phys];
            state_nxt  = tcs_pkg::ST_READ;
          end
          default: begin
            state_nxt = tcs_pkg::ST_DONE;
          end
        endcase
      end

      tcs_pkg::ST_PUT: begin
        put_pend_nxt = 1'b0;
        ram_we       = 1'b1;
        ram_waddr    = {cur_row, cur_r};
        ram_wdata    = ch_r;
        if (cur_inc >= cols) begin
          cur_nxt    = '0;
          lt_nxt     = adv_lt;
          base_nxt   = adv_base;
          sw_row_nxt = adv_row;
          sw_col_nxt = '0;
          state_nxt  = tcs_pkg::ST_SWEEP;
        end else begin
          cur_nxt   = CW'(cur_inc);
          state_nxt = tcs_pkg::ST_DONE;
        end
      end

      tcs_pkg::ST_SWEEP: begin
        ram_we     = 1'b1;
        sw_col_nxt = sw_col_r + CW'(1);
        if (sw_col_r == CW'(tcs_pkg::MAX_COLS - 1)) begin
          sw_col_nxt              = '0;
          row_valid_nxt[sw_row_r] = 1'b1;
          boot_nxt                = 1'b0;
          if (put_pend_r) begin
            state_nxt = tcs_pkg::ST_PUT;
          end else if (boot_r) begin
            state_nxt = tcs_pkg::ST_IDLE;
          end else begin
            state_nxt = tcs_pkg::ST_DONE;
          end
        end
      end

      tcs_pkg::ST_READ: begin
        if (!rd_hit_r) begin
          rd_char_nxt = '0;
        end else if (rd_vld_r) begin
          rd_char_nxt = ram_q;
        end else begin
          rd_char_nxt = tcs_pkg::CH_SPACE;
        end
        state_nxt = tcs_pkg::ST_DONE;
      end

      tcs_pkg::ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt = {2'b00,
                           tcs_pkg::VIEWO_W'(sb_r),
                           tcs_pkg::LINEO_W'(lt_r),
                           tcs_pkg::CURO_W'(cur_r),
                           rd_char_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = tcs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = tcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tcs_pkg::ST_SWEEP;
      cur_r        <= '0;
      lt_r         <= LW'(1);
      sb_r         <= '0;
      base_r       <= '0;
      row_valid_r  <= '0;
      sw_row_r     <= '0;
      sw_col_r     <= '0;
      put_pend_r   <= 1'b0;
      boot_r       <= 1'b1;
      out_tvalid_r <= 1'b0;
      cfg_cols_r   <= tcs_pkg::COLS_RESET;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      lt_r         <= lt_nxt;
      sb_r         <= sb_nxt;
      base_r       <= base_nxt;
      row_valid_r  <= row_valid_nxt;
      sw_row_r     <= sw_row_nxt;
      sw_col_r     <= sw_col_nxt;
      put_pend_r   <= put_pend_nxt;
      boot_r       <= boot_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr) begin
        cfg_cols_r <= cfg_pwdata[tcs_pkg::CFG_COLS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_hit_r    <= rd_hit_nxt;
    rd_vld_r    <= rd_vld_nxt;
    rd_char_r   <= rd_char_nxt;
    out_tdata_r <= out_tdata_nxt;
    if (in_beat) begin
      req_r   <= tcs_pkg::req_t'(in_tuser);
      ch_r    <= in_tdata[7:0];
      delta_r <= in_tdata[15:8];
      rrow_r  <= in_tdata[22:16];
      rcol_r  <= in_tdata[29:23];
    end
  end

endmodule
`default_nettype wire
